/* rtl/core/arp_cache_table_defines.svh */
// Assertion macros shared by the table's checking code.
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/arpc_pkg.sv */
`default_nettype none

package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [IP_W-1:0]  ip_address;
        logic [MAC_W-1:0] mac_address;
    } arpc_req_t;

    typedef struct packed {
        logic             found;
        logic [MAC_W-1:0] mac_result;
        logic             dropped;
    } arpc_rsp_t;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             opcode;
        logic             found;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arpc_tok_t;

endpackage

`default_nettype wire

/* rtl/core/arpc_cell.sv */
`default_nettype none

module arpc_cell
    import arpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire arpc_tok_t tok_in,
    output arpc_tok_t      tok_out
);

    logic             used_reg;
    logic             used_next;
    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    arpc_tok_t        tok_reg;
    arpc_tok_t        tok_next;
    logic             take_insert;
    logic             lookup_hit;

    always_comb
    begin
        take_insert = tok_in.valid && !tok_in.found && (tok_in.opcode == OP_INSERT)
                      && !used_reg;
        lookup_hit  = tok_in.valid && !tok_in.found && (tok_in.opcode == OP_LOOKUP)
                      && used_reg && (ip_reg == tok_in.ip);
        used_next   = used_reg | take_insert;
        tok_next    = tok_in;
        if (take_insert)
        begin
            tok_next.found = 1'b1;
        end
        if (lookup_hit)
        begin
            // carry the stored MAC onward
            tok_next.found = 1'b1;
            tok_next.mac   = mac_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_insert)
        begin
            ip_reg  <= tok_in.ip;
            mac_reg <= tok_in.mac;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

/* rtl/core/arp_cache_table.sv */
// IPv4-to-MAC address table built as a chain of entry cells.
//
// Request channel (req, req_valid, req_stall): one beat carries an opcode,
// an IP address and a MAC address. Insert stores the pair in the lowest
// unused entry; lookup returns the MAC of the lowest used entry whose IP
// matches. Response channel (rsp, rsp_valid, rsp_stall): one beat per request
// with found, mac_result and dropped (insert into a full table).
//
// A request becomes a token that steps through one cell per cycle, passing
// each cell's register, then the holding register, then the response
// register before rsp_valid rises. Only one token is in the chain at a time:
// req_stall stays high from acceptance until the result moves into the
// response register, so no new request is taken before then.
//
// The response register parts the two sides: while a result waits under
// rsp_stall, the next request is accepted and walks the chain; it then waits
// in a holding register, and further requests stall until it moves out.
//
// Reset clears every entry's used mark, so the table starts empty, and
// drops any request in flight.
`default_nettype none
`include "arp_cache_table_defines.svh"

module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire arpc_req_t req,
    input  wire logic      req_valid,
    output logic           req_stall,
    output arpc_rsp_t      rsp,
    output logic           rsp_valid,
    input  wire logic      rsp_stall
);

    arpc_tok_t chain [TABLE_ENTRIES+1];

    logic      busy_reg;
    logic      busy_next;
    logic      pend_valid_reg;
    logic      pend_valid_next;
    arpc_rsp_t pend_reg;
    arpc_rsp_t pend_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    arpc_rsp_t rsp_reg;
    logic      req_take;
    logic      pend_move;
    arpc_tok_t tail;

    // Launch a token at the head of the chain on each request beat.
    assign req_take = req_valid && !busy_reg;

    assign chain[0] = '{valid:  req_take,
                        opcode: req.opcode,
                        found:  1'b0,
                        ip:     req.ip_address,
                        mac:    req.mac_address};

    for (genvar k = 0; k < TABLE_ENTRIES; k++)
    begin : g_cell
        arpc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign tail = chain[TABLE_ENTRIES];

    // Turn the finished token into a response: hold the MAC only on a hit.
    always_comb
    begin
        pend_next.found      = tail.found;
        pend_next.mac_result = (tail.opcode == OP_LOOKUP && tail.found) ? tail.mac
                                                                        : '0;
        pend_next.dropped    = (tail.opcode == OP_INSERT) && !tail.found;
    end

    always_comb
    begin
        pend_move       = pend_valid_reg && (!rsp_valid_reg || !rsp_stall);
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        rsp_valid_next  = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            rsp_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (tail.valid)
        begin
            pend_valid_next = 1'b1;
        end
        if (req_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pend_reg <= pend_next;
        end
        if (pend_move)
        begin
            rsp_reg <= pend_reg;
        end
    end

    assign req_stall = busy_reg;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `ARPC_ASSERT_NOW(a_pend_busy, pend_valid_reg, busy_reg, "held result without busy")
    `ARPC_ASSERT_NOW(a_tail_free, tail.valid, !pend_valid_reg, "token overran held result")
    `ARPC_ASSERT_NEXT(a_take_busy, req_take, busy_reg, "request taken but chain not busy")
    `ARPC_ASSERT_NOW(a_rsp_excl, rsp_valid_reg, !(rsp_reg.found && rsp_reg.dropped),
        "result both found and dropped")

endmodule

`default_nettype wire
